// ----- hw/rtl/lru_recency_list_core_defines.svh -----
// Assertion macros used by the recency list core.
`ifndef LRU_RECENCY_LIST_CORE_DEFINES_SVH
`define LRU_RECENCY_LIST_CORE_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define LRL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define LRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Like LRL_ASSERT_NEXT, but with a further delay before the consequence is checked.
`define LRL_ASSERT_LATER(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lrl_pkg.sv -----
package lrl_pkg;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 4;
    localparam int PAGE_W = 32;

    localparam int DEF_ENTRIES  = 16;
    localparam int DEF_KEY_BITS = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [PAGE_W-1:0] page_key;
    } req_t;

    typedef struct packed {
        logic              evicted_valid;
        logic [SLOT_W-1:0] evicted_slot;
        logic [PAGE_W-1:0] evicted_page;
        logic [SLOT_W-1:0] head_slot;
        logic [SLOT_W-1:0] tail_slot;
        logic              list_empty;
    } rsp_t;

endpackage

// ----- hw/rtl/lru_recency_list_core.sv -----
// LRU recency list: keeps the use order of ENTRIES cache slots as a doubly
// linked list, with the next and prev links and the page keys in RAM.
// A command beat (insert at head, move to head, evict tail) is taken on req
// at a clock edge where start is high and busy is low. Busy then stays high
// for one cycle while the links read at the accept edge come back and the
// neighbor links are rewritten. The result beat appears on rsp for exactly
// one cycle with done high, as done and rsp are registered at the end of the
// busy cycle; there is no way to hold it off.
// A new command can be accepted in the same cycle the result is shown, but
// not while busy is high, as the registered read of the link RAMs must be
// followed by their write-back.
// Writes that do not depend on the read data go to the RAMs at the accept
// edge, so each RAM sees at most one write per cycle.
// An evict on an empty list reports evicted_valid low and changes nothing.
// Reset empties the list at once; the RAM contents are not cleared and are
// only read where a valid link bit says they were written.
`include "lru_recency_list_core_defines.svh"

module lru_recency_list_core #(
    parameter int ENTRIES  = lrl_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = lrl_pkg::DEF_KEY_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lrl_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output lrl_pkg::rsp_t rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KW = (KEY_BITS > lrl_pkg::PAGE_W) ? KEY_BITS : lrl_pkg::PAGE_W;
    localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                           state_reg;
    logic [lrl_pkg::CMD_W-1:0]      cmd_reg;
    logic [IW-1:0]                  slot_reg;
    logic                           act_reg;
    logic [IW-1:0]                  head_reg;
    logic [IW-1:0]                  tail_reg;
    logic                           occ_reg;
    logic [ENTRIES-1:0]             vn_reg;
    logic [ENTRIES-1:0]             vp_reg;
    logic                           done_reg;
    lrl_pkg::rsp_t                  rsp_reg;

    logic [IW-1:0]                  head_next;
    logic [IW-1:0]                  tail_next;
    logic                           occ_next;
    logic [ENTRIES-1:0]             vn_next;
    logic [ENTRIES-1:0]             vp_next;
    lrl_pkg::rsp_t                  rsp_next;

    logic                           accept;
    logic                           in_slot_ok;
    logic [IW-1:0]                  in_slot;
    logic                           in_act;
    logic [IW-1:0]                  rd_addr;
    logic                           pre_next_we;
    logic                           pre_prev_we;
    logic                           page_we;

    logic [IW-1:0]                  u_s;
    logic [IW-1:0]                  nx;
    logic [IW-1:0]                  pv;
    logic                           hn;
    logic                           hp;
    logic                           is_ins;
    logic                           is_mv;
    logic                           is_ev;
    logic                           do_unlink;
    logic                           do_link;
    logic                           at_head;
    logic                           at_tail;
    logic                           middle;
    logic [IW-1:0]                  head_mid;
    logic                           occ_mid;

    logic                           ex_next_we;
    logic [IW-1:0]                  ex_next_data;
    logic                           ex_prev_we;
    logic [IW-1:0]                  ex_prev_data;

    logic                           next_we;
    logic [IW-1:0]                  next_waddr;
    logic [IW-1:0]                  next_wdata;
    logic                           prev_we;
    logic [IW-1:0]                  prev_waddr;
    logic [IW-1:0]                  prev_wdata;
    logic [KEY_BITS-1:0]            page_rdata;
    logic [KW-1:0]                  page_wide;

    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && (state_reg == ST_IDLE);

    // Accept side: decode the command and issue the reads of the slot's links.
    assign in_slot_ok = (32'(req.slot) < ENTRIES_W);
    assign in_slot    = IW'(req.slot);

    always_comb
    begin
        unique case (req.cmd)
            lrl_pkg::CMD_INSERT: in_act = in_slot_ok;
            lrl_pkg::CMD_MOVE:   in_act = in_slot_ok;
            lrl_pkg::CMD_EVICT:  in_act = occ_reg;
            default:             in_act = 1'b0;
        endcase
    end

    assign rd_addr = (req.cmd == lrl_pkg::CMD_EVICT) ? tail_reg : in_slot;

    // The new head's next link and the old head's prev link do not depend on the
    // read data unless the slot is already the head, so they are written at the accept edge.
    assign pre_next_we = accept && in_act && occ_reg &&
                         ((req.cmd == lrl_pkg::CMD_INSERT) ||
                          ((req.cmd == lrl_pkg::CMD_MOVE) && (head_reg != in_slot)));
    assign pre_prev_we = accept && in_act && occ_reg &&
                         ((req.cmd == lrl_pkg::CMD_INSERT) ||
                          ((req.cmd == lrl_pkg::CMD_MOVE) && (head_reg != in_slot) &&
                           ((tail_reg != in_slot) || vp_reg[in_slot])));
    assign page_we     = accept && in_act && (req.cmd == lrl_pkg::CMD_INSERT);

    // Execute side: the slot's links are back from the RAMs.
    assign is_ins = (cmd_reg == lrl_pkg::CMD_INSERT);
    assign is_mv  = (cmd_reg == lrl_pkg::CMD_MOVE);
    assign is_ev  = (cmd_reg == lrl_pkg::CMD_EVICT);
    assign u_s    = is_ev ? tail_reg : slot_reg;
    assign hn     = vn_reg[u_s];
    assign hp     = vp_reg[u_s];

    assign do_unlink = busy && act_reg && (is_mv || is_ev) && occ_reg;
    assign do_link   = busy && act_reg && (is_ins || is_mv);
    assign at_head   = (head_reg == u_s);
    assign at_tail   = (tail_reg == u_s);
    assign middle    = do_unlink && !at_head && !at_tail;

    always_comb
    begin
        head_mid  = head_reg;
        tail_next = tail_reg;
        occ_mid   = occ_reg;
        vn_next   = vn_reg;
        vp_next   = vp_reg;
        if (do_unlink)
        begin
            priority if (at_head)
            begin
                if (hn)
                begin
                    vp_next[nx] = 1'b0;
                    head_mid    = nx;
                end
                else
                begin
                    occ_mid   = 1'b0;
                    head_mid  = '0;
                    tail_next = '0;
                end
            end
            else if (at_tail)
            begin
                if (hp)
                begin
                    vn_next[pv] = 1'b0;
                    tail_next   = pv;
                end
                else
                begin
                    occ_mid   = 1'b0;
                    head_mid  = '0;
                    tail_next = '0;
                end
            end
            else
            begin
                if (hp)
                begin
                    vn_next[pv] = hn;
                end
                if (hn)
                begin
                    vp_next[nx] = hp;
                end
            end
            vn_next[u_s] = 1'b0;
            vp_next[u_s] = 1'b0;
        end

        head_next = head_mid;
        occ_next  = occ_mid;
        if (do_link)
        begin
            vp_next[slot_reg] = 1'b0;
            head_next         = slot_reg;
            if (!occ_mid)
            begin
                vn_next[slot_reg] = 1'b0;
                tail_next         = slot_reg;
                occ_next          = 1'b1;
            end
            else
            begin
                vn_next[slot_reg] = 1'b1;
                vp_next[head_mid] = 1'b1;
            end
        end
    end

    // Neighbor rewrites. Where one lands on an entry already written at the
    // accept edge, the head link wins, as it comes last in the list update.
    assign ex_next_we   = middle && hp;
    assign ex_next_data = (pv == slot_reg) ? head_reg : nx;
    assign ex_prev_we   = (middle && hn) || (do_unlink && is_mv && at_head && hn);
    assign ex_prev_data = (middle && (nx != head_reg)) ? pv : slot_reg;

    assign next_we    = pre_next_we || ex_next_we;
    assign next_waddr = pre_next_we ? in_slot : pv;
    assign next_wdata = pre_next_we ? head_reg : ex_next_data;
    assign prev_we    = pre_prev_we || ex_prev_we;
    assign prev_waddr = pre_prev_we ? head_reg : nx;
    assign prev_wdata = pre_prev_we ? in_slot : ex_prev_data;

    lrl_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (IW)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (nx)
    );

    lrl_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (IW)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (pv)
    );

    lrl_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (KEY_BITS)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (in_slot),
        .wdata (KEY_BITS'(req.page_key)),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (page_rdata)
    );

    assign page_wide = KW'(page_rdata);

    always_comb
    begin
        rsp_next.evicted_valid = is_ev && act_reg;
        rsp_next.evicted_slot  = (is_ev && act_reg) ? lrl_pkg::SLOT_W'(tail_reg) : '0;
        rsp_next.evicted_page  = (is_ev && act_reg) ? page_wide[lrl_pkg::PAGE_W-1:0] : '0;
        rsp_next.head_slot     = occ_next ? lrl_pkg::SLOT_W'(head_next) : '0;
        rsp_next.tail_slot     = occ_next ? lrl_pkg::SLOT_W'(tail_next) : '0;
        rsp_next.list_empty    = !occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= lrl_pkg::CMD_INSERT;
            slot_reg  <= '0;
            act_reg   <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= 1'b0;
            vn_reg    <= '0;
            vp_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy;
            if (accept)
            begin
                state_reg <= ST_EXEC;
                cmd_reg   <= req.cmd;
                slot_reg  <= in_slot;
                act_reg   <= in_act;
            end
            else if (busy)
            begin
                state_reg <= ST_IDLE;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                occ_reg   <= occ_next;
                vn_reg    <= vn_next;
                vp_reg    <= vp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `LRL_ASSERT_NEXT(a_exec_done, state_reg == ST_EXEC, done_reg && state_reg == ST_IDLE, "command did not finish in one execute cycle")
    `LRL_ASSERT_NOW(a_empty_ptrs, !occ_reg, head_reg == '0 && tail_reg == '0, "empty list with nonzero head or tail")
    `LRL_ASSERT_NOW(a_evict_only, done_reg && rsp_reg.evicted_valid, cmd_reg == lrl_pkg::CMD_EVICT, "eviction reported for a non-evict command")
    `LRL_ASSERT_LATER(a_insert_fills, accept && in_slot_ok && req.cmd == lrl_pkg::CMD_INSERT, occ_reg && done_reg && !rsp_reg.list_empty, "insert left the list empty")

endmodule

// ----- hw/rtl/lrl_ram.sv -----
module lrl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read and a write of the same entry return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- tb/sv/lru_recency_list_core_checker.sv -----
`timescale 1ns / 1ps

module lru_recency_list_core_checker
    import lrl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  rsp_t rsp,
    output int   fail_count
);

    // Shadow copy of the recency list, updated once per accepted command beat.
    logic [SLOT_W-1:0] next_of [DEF_ENTRIES];
    logic [SLOT_W-1:0] prev_of [DEF_ENTRIES];
    bit                has_next [DEF_ENTRIES];
    bit                has_prev [DEF_ENTRIES];
    logic [PAGE_W-1:0] page_of [DEF_ENTRIES];
    logic [SLOT_W-1:0] mru;
    logic [SLOT_W-1:0] lru;
    bit                listed;

    rsp_t predicted_rsp [$];
    int   mismatches = 0;

    function automatic void detach(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] pv;
        bit                hn;
        bit                hp;
        nx = next_of[s];
        pv = prev_of[s];
        hn = has_next[s];
        hp = has_prev[s];
        if (!listed)
            return;
        if (mru == s)
        begin
            if (hn)
            begin
                has_prev[nx] = 1'b0;
                mru = nx;
            end
            else
            begin
                listed = 1'b0;
                mru = '0;
                lru = '0;
            end
        end
        else if (lru == s)
        begin
            if (hp)
            begin
                has_next[pv] = 1'b0;
                lru = pv;
            end
            else
            begin
                listed = 1'b0;
                mru = '0;
                lru = '0;
            end
        end
        else
        begin
            if (hp)
            begin
                next_of[pv] = nx;
                has_next[pv] = hn;
            end
            if (hn)
            begin
                prev_of[nx] = pv;
                has_prev[nx] = hp;
            end
        end
        has_next[s] = 1'b0;
        has_prev[s] = 1'b0;
    endfunction

    function automatic void attach_front(input logic [SLOT_W-1:0] s);
        has_prev[s] = 1'b0;
        if (!listed)
        begin
            has_next[s] = 1'b0;
            mru = s;
            lru = s;
            listed = 1'b1;
            return;
        end
        next_of[s] = mru;
        has_next[s] = 1'b1;
        prev_of[mru] = s;
        has_prev[mru] = 1'b1;
        mru = s;
    endfunction

    function automatic rsp_t recency_update(input req_t r);
        rsp_t              res;
        logic [SLOT_W-1:0] victim;
        res = '0;
        if (r.cmd == CMD_INSERT)
        begin
            page_of[r.slot] = r.page_key;
            attach_front(r.slot);
        end
        else if (r.cmd == CMD_MOVE)
        begin
            detach(r.slot);
            attach_front(r.slot);
        end
        else if (r.cmd == CMD_EVICT && listed)
        begin
            victim = lru;
            res.evicted_valid = 1'b1;
            res.evicted_slot = victim;
            res.evicted_page = page_of[victim];
            detach(victim);
        end
        res.head_slot = listed ? mru : '0;
        res.tail_slot = listed ? lru : '0;
        res.list_empty = !listed;
        return res;
    endfunction

    function automatic void check_rsp(input rsp_t got, input rsp_t want);
        if (got.evicted_valid !== want.evicted_valid)
        begin
            $error("evicted_valid: expected %0d, got %0d", want.evicted_valid, got.evicted_valid);
            mismatches++;
        end
        if (got.evicted_slot !== want.evicted_slot)
        begin
            $error("evicted_slot: expected %0d, got %0d", want.evicted_slot, got.evicted_slot);
            mismatches++;
        end
        if (got.evicted_page !== want.evicted_page)
        begin
            $error("evicted_page: expected %08h, got %08h", want.evicted_page, got.evicted_page);
            mismatches++;
        end
        if (got.head_slot !== want.head_slot)
        begin
            $error("head_slot: expected %0d, got %0d", want.head_slot, got.head_slot);
            mismatches++;
        end
        if (got.tail_slot !== want.tail_slot)
        begin
            $error("tail_slot: expected %0d, got %0d", want.tail_slot, got.tail_slot);
            mismatches++;
        end
        if (got.list_empty !== want.list_empty)
        begin
            $error("list_empty: expected %0d, got %0d", want.list_empty, got.list_empty);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEF_ENTRIES; i++)
            begin
                next_of[i] = '0;
                prev_of[i] = '0;
                has_next[i] = 1'b0;
                has_prev[i] = 1'b0;
                page_of[i] = '0;
            end
            mru = '0;
            lru = '0;
            listed = 1'b0;
            predicted_rsp.delete();
            fail_count <= mismatches;
        end
        else
        begin
            // The result of an older beat leaves the queue before a beat
            // accepted at this same edge joins it.
            if (done)
            begin
                if (predicted_rsp.size() == 0)
                begin
                    $error("result beat arrived with no command outstanding");
                    mismatches++;
                end
                else
                    check_rsp(rsp, predicted_rsp.pop_front());
            end
            if (start && !busy)
                predicted_rsp.push_back(recency_update(req));
            fail_count <= mismatches + predicted_rsp.size();
        end
    end

endmodule

// ----- tb/sv/lru_recency_list_core_tb.sv -----
`timescale 1ns / 1ps

module lru_recency_list_core_tb;
    import lrl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 650;
    localparam int DRAIN_MAX   = 40;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam rsp_t RSP_EMPTY = '{list_empty: 1'b1, default: '0};

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    rsp_t rsp;
    int   fail_count;

    int   cycles = 0;
    int   results_seen = 0;
    int   accepted = 0;
    int   counted = 0;
    int   idle_pct = 32;
    int   n_insert = 0;
    int   n_move = 0;
    int   n_evict = 0;
    int   n_unused = 0;
    int   n_drains = 0;
    rsp_t last_rsp;

    // Slots in use order as the stimulus side believes it, most recent first.
    // Only trusted while every command so far kept the list well formed.
    logic [SLOT_W-1:0] use_order [$];
    bit                order_lost = 1'b0;
    bit                page_set [DEF_ENTRIES];

    lru_recency_list_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    lru_recency_list_core_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (!rst_n)
            last_rsp <= RSP_EMPTY;
        else if (done)
        begin
            results_seen <= results_seen + 1;
            last_rsp <= rsp;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles without finishing.", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int order_pos(input logic [SLOT_W-1:0] s);
        for (int i = 0; i < use_order.size(); i++)
            if (use_order[i] == s)
                return i;
        return -1;
    endfunction

    function automatic int pick_written();
        int base;
        base = $urandom_range(DEF_ENTRIES - 1);
        for (int i = 0; i < DEF_ENTRIES; i++)
            if (page_set[(base + i) % DEF_ENTRIES])
                return (base + i) % DEF_ENTRIES;
        return -1;
    endfunction

    function automatic logic [PAGE_W-1:0] rand_key();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic note_order(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s);
        int pos;
        pos = order_pos(s);
        if (order_lost)
            return;
        if (c == CMD_INSERT)
        begin
            if (pos >= 0)
                order_lost = 1'b1;
            else
                use_order.push_front(s);
        end
        else if (c == CMD_MOVE)
        begin
            if (pos >= 0)
            begin
                use_order.delete(pos);
                use_order.push_front(s);
            end
            else if (use_order.size() == 0)
                use_order.push_front(s);
            else
                order_lost = 1'b1;
        end
        else if (c == CMD_EVICT && use_order.size() > 0)
            void'(use_order.pop_back());
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
                            input logic [PAGE_W-1:0] k);
        req_t r;
        int   gap;
        r.cmd = c;
        r.slot = s;
        r.page_key = k;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 4);
        repeat (gap) @(negedge clk) start <= 1'b0;
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        accepted++;
        note_order(c, s);
        case (c)
            CMD_INSERT:
            begin
                n_insert++;
                page_set[s] = 1'b1;
            end
            CMD_MOVE:   n_move++;
            CMD_EVICT:  n_evict++;
            default:    n_unused++;
        endcase
        if (c != CMD_UNUSED)
            counted++;
    endtask

    task automatic wait_all();
        @(negedge clk) start <= 1'b0;
        while (results_seen != accepted)
            @(posedge clk);
    endtask

    // Evicts one beat at a time, waiting on each result, until the block
    // reports an empty list. A malformed list may not empty within the bound.
    task automatic drain_list();
        int n;
        n = 0;
        wait_all();
        while (!last_rsp.list_empty && n < DRAIN_MAX)
        begin
            send_cmd(CMD_EVICT, SLOT_W'($urandom_range(DEF_ENTRIES - 1)), $urandom);
            wait_all();
            n++;
        end
        if (last_rsp.list_empty)
        begin
            use_order.delete();
            order_lost = 1'b0;
        end
        n_drains++;
    endtask

    task automatic sensible_cmd();
        int                w;
        int                ws;
        logic [SLOT_W-1:0] s;
        w = $urandom_range(99);
        if (use_order.size() == 0)
        begin
            ws = pick_written();
            if (w < 10)
                send_cmd(CMD_EVICT, SLOT_W'($urandom_range(DEF_ENTRIES - 1)), $urandom);
            else if (w < 20 && ws >= 0)
                send_cmd(CMD_MOVE, SLOT_W'(ws), rand_key());
            else
                send_cmd(CMD_INSERT, SLOT_W'($urandom_range(DEF_ENTRIES - 1)), rand_key());
        end
        else if (w < 40 && use_order.size() < DEF_ENTRIES)
        begin
            s = SLOT_W'($urandom_range(DEF_ENTRIES - 1));
            while (order_pos(s) >= 0)
                s = SLOT_W'($urandom_range(DEF_ENTRIES - 1));
            send_cmd(CMD_INSERT, s, rand_key());
        end
        else if (w < 75)
        begin
            // Favor the two ends now and then, where the links differ most.
            case ($urandom_range(3))
                0:       s = use_order[0];
                1:       s = use_order[use_order.size() - 1];
                default: s = use_order[$urandom_range(use_order.size() - 1)];
            endcase
            send_cmd(CMD_MOVE, s, rand_key());
        end
        else
            send_cmd(CMD_EVICT, SLOT_W'($urandom_range(DEF_ENTRIES - 1)), $urandom);
    endtask

    task automatic noise_cmd();
        logic [CMD_W-1:0] c;
        int               s;
        c = CMD_W'($urandom_range(3));
        s = $urandom_range(DEF_ENTRIES - 1);
        // A move must not bring in a slot whose page key was never stored.
        if (c == CMD_MOVE && !page_set[s])
        begin
            s = pick_written();
            if (s < 0)
            begin
                c = CMD_INSERT;
                s = $urandom_range(DEF_ENTRIES - 1);
            end
        end
        send_cmd(c, SLOT_W'(s), rand_key());
    endtask

    initial
    begin
        int len;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        for (int i = 0; i < DEF_ENTRIES; i++)
            page_set[i] = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        send_cmd(CMD_EVICT, 4'd0, 32'h0);
        send_cmd(CMD_UNUSED, 4'hA, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 4'd0, 32'h0000_0000);
        send_cmd(CMD_INSERT, 4'd15, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 4'd5, 32'hA5A5_A5A5);
        send_cmd(CMD_MOVE, 4'd0, $urandom);
        send_cmd(CMD_MOVE, 4'd0, $urandom);
        send_cmd(CMD_MOVE, 4'd5, $urandom);
        send_cmd(CMD_EVICT, 4'd0, 32'h0);
        send_cmd(CMD_EVICT, 4'd0, 32'h0);
        // Detaching the last entry must leave no stale tail behind.
        send_cmd(CMD_EVICT, 4'd0, 32'h0);
        send_cmd(CMD_EVICT, 4'd0, 32'h0);
        send_cmd(CMD_MOVE, 4'd15, $urandom);
        send_cmd(CMD_INSERT, 4'd15, 32'h1234_5678);
        drain_list();
        send_cmd(CMD_INSERT, 4'd3, 32'h5A5A_5A5A);
        send_cmd(CMD_MOVE, 4'd0, $urandom);
        send_cmd(CMD_UNUSED, 4'd5, 32'h0);
        drain_list();

        while (counted < ITEM_TARGET)
        begin
            if (counted < ITEM_TARGET / 3)
                idle_pct = 32;
            else if (counted < 2 * ITEM_TARGET / 3)
                idle_pct = 59;
            else
                idle_pct = 0;
            len = $urandom_range(4, 40);
            repeat (len)
            begin
                if (order_lost || $urandom_range(99) < 6)
                    noise_cmd();
                else
                    sensible_cmd();
            end
            if (order_lost || $urandom_range(99) < 35)
                drain_list();
        end

        wait_all();
        repeat (SETTLE) @(posedge clk);
        $display("Checked %0d command beats: %0d inserts, %0d moves, %0d evicts, %0d unused codes.",
                 accepted, n_insert, n_move, n_evict, n_unused);
        $display("Command idling at 32, 59 and 0 percent; %0d pauses drained the list to empty.",
                 n_drains);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
